// File: rtl/core/wsrag_pkg.sv
// shared constants, codes and state types of the windowed spread/range activity gate
`default_nettype none
package wsrag_pkg;
    localparam int NUM_SYMBOLS_DEF  = 8;
    localparam int WINDOW_DEPTH_DEF = 64;

    localparam int SYM_W      = 3;
    localparam int TIME_W     = 48;
    localparam int MID_W      = 32;
    localparam int SPR_W      = 16;
    localparam int OUT_W      = 24;
    localparam int WIN_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int SCALE_W    = 22;
    localparam int PROD_W     = MID_W + SCALE_W;

    // 10000 bps times 256
    localparam logic [SCALE_W-1:0] SCALE_BPS = 22'd2560000;
    localparam logic [OUT_W-1:0]   SAT_MAX   = {OUT_W{1'b1}};

    localparam logic [WIN_W-1:0] WINDOW_MS_RST      = 32'd1000;
    localparam logic [OUT_W-1:0] MAX_AVG_SPREAD_RST = 24'd384;
    localparam logic [OUT_W-1:0] MIN_RANGE_RST      = 24'd128;
    localparam logic [OUT_W-1:0] MIN_ACTIVITY_RST   = 24'd128;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AVG_SPREAD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVITY   = 8'd3;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHK,
        DV_RUN,
        DV_DONE
    } t_div_state;

    typedef enum logic [3:0] {
        GS_IDLE,
        GS_PR_RD,
        GS_PR_CHK,
        GS_W_RD,
        GS_W_ACC,
        GS_W_DIV,
        GS_W_NEXT,
        GS_AVG_GO,
        GS_AVG_W,
        GS_RNG_GO,
        GS_RNG_W,
        GS_DONE
    } t_gate_state;
endpackage
`default_nettype wire

// File: rtl/core/wsrag_if.sv
// channel interfaces: sample/query input, statistics output, register write
`default_nettype none
interface wsrag_in_if import wsrag_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [SYM_W-1:0]  symbol_index;
    logic [TIME_W-1:0] time_ms;
    logic [MID_W-1:0]  mid_price;
    logic [SPR_W-1:0]  spread_bps;
    modport source (output valid, command, symbol_index, time_ms, mid_price, spread_bps,
                    input ready);
    modport sink (input valid, command, symbol_index, time_ms, mid_price, spread_bps,
                  output ready);
endinterface

interface wsrag_out_if import wsrag_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             has_data;
    logic [OUT_W-1:0] avg_spread;
    logic [OUT_W-1:0] short_range;
    logic [OUT_W-1:0] activity;
    logic             tradable;
    modport source (output valid, has_data, avg_spread, short_range, activity, tradable,
                    input ready);
    modport sink (input valid, has_data, avg_spread, short_range, activity, tradable,
                  output ready);
endinterface

interface wsrag_cfg_if import wsrag_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wsrag_div.sv
// shared serial divider, optional scale by 2560000, quotient saturated to 24 bits
`default_nettype none
module wsrag_div import wsrag_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [MID_W-1:0] i_a,
    input  wire logic [MID_W-1:0] i_b,
    input  wire logic             i_scale,
    output logic                  o_done,
    output logic [OUT_W-1:0]      o_q
);
    t_div_state r_state, n_state;
    logic [PROD_W-1:0] r_num;
    logic [MID_W-1:0]  r_den;
    logic [MID_W:0]    r_rem;
    logic [OUT_W-1:0]  r_lo;
    logic [OUT_W-1:0]  r_q;
    logic [4:0]        r_cnt;

    logic              sat;
    logic [MID_W:0]    trial;
    logic              take;

    assign sat   = {2'b00, r_num} >= {r_den, {OUT_W{1'b0}}};
    assign trial = {r_rem[MID_W-1:0], r_lo[OUT_W-1]};
    assign take  = trial >= {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: if (i_start) n_state = DV_CHK;
            DV_CHK:  n_state = sat ? DV_DONE : DV_RUN;
            DV_RUN:  if (r_cnt == 5'(OUT_W - 1)) n_state = DV_DONE;
            DV_DONE: n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == DV_DONE);
        o_q    = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_num <= i_scale ? PROD_W'(i_a * SCALE_BPS) : PROD_W'(i_a);
                    r_den <= i_b;
                end
            end
            DV_CHK: begin
                r_rem <= (MID_W+1)'(r_num[PROD_W-1:OUT_W]);
                r_lo  <= r_num[OUT_W-1:0];
                r_cnt <= '0;
                r_q   <= sat ? SAT_MAX : '0;
            end
            DV_RUN: begin
                r_rem <= take ? trial - {1'b0, r_den} : trial;
                r_lo  <= {r_lo[OUT_W-2:0], 1'b0};
                r_q   <= {r_q[OUT_W-2:0], take};
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/windowed_spread_range_activity_gate.sv
// top level: sample rings, query sequencer and statistics output register
// store: accepted back to back; no result
// query: prune expired samples, walk the retained ones, then divide for average and range
//   (one shared serial divider, 24 quotient bits at one bit a cycle, per ratio)
// a full ring holds 64 entries; the input is not ready while a query runs
// synchronous active-low reset empties all rings and loads the register defaults
`default_nettype none
module windowed_spread_range_activity_gate import wsrag_pkg::*; #(
    parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wsrag_in_if.sink   i_in,
    wsrag_out_if.source o_out,
    wsrag_cfg_if.sink  i_cfg
);
    localparam int HW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int AW    = $clog2(NUM_SYMBOLS * WINDOW_DEPTH);
    localparam int SUM_W = SPR_W + CW;
    localparam int ENT   = NUM_SYMBOLS * WINDOW_DEPTH;

    // configuration registers
    logic [WIN_W-1:0] r_window_ms;
    logic [OUT_W-1:0] r_max_avg_spread;
    logic [OUT_W-1:0] r_min_range;
    logic [OUT_W-1:0] r_min_activity;

    // ring bookkeeping, one head and count per slot
    logic [HW-1:0] r_head  [NUM_SYMBOLS];
    logic [CW-1:0] r_count [NUM_SYMBOLS];

    // sample memories with registered read
    logic [TIME_W-1:0] mem_time   [ENT];
    logic [MID_W-1:0]  mem_mid    [ENT];
    logic [SPR_W-1:0]  mem_spread [ENT];
    logic [TIME_W-1:0] r_q_time;
    logic [MID_W-1:0]  r_q_mid;
    logic [SPR_W-1:0]  r_q_spread;

    t_gate_state r_state, n_state;

    // query context
    logic [SW-1:0]     r_sym;
    logic [TIME_W-1:0] r_now;
    logic [CW-1:0]     r_n;
    logic [CW-1:0]     r_i;
    logic [HW-1:0]     r_ptr;
    logic [SUM_W-1:0]  r_sum;
    logic [MID_W-1:0]  r_lo;
    logic [MID_W-1:0]  r_hi;
    logic [MID_W-1:0]  r_prev;
    logic [OUT_W-1:0]  r_act;
    logic [OUT_W-1:0]  r_avg;
    logic [OUT_W-1:0]  r_rng;
    logic              r_has;

    // output register
    logic              r_ov;
    logic              r_o_has;
    logic [OUT_W-1:0]  r_o_avg;
    logic [OUT_W-1:0]  r_o_rng;
    logic [OUT_W-1:0]  r_o_act;
    logic              r_o_trd;

    // input decode
    logic [8:0]    in_sym_ext;
    logic          in_sym_ok;
    logic [SW-1:0] in_sym;
    logic          in_xfer;
    logic          store_we;
    logic [HW-1:0] st_head;
    logic [CW-1:0] st_count;
    logic          st_full;
    logic [CW:0]   st_sum;
    logic [HW-1:0] st_slot;
    logic [AW-1:0] wr_addr;

    assign in_sym_ext = {{(9 - SYM_W){1'b0}}, i_in.symbol_index};
    assign in_sym_ok  = in_sym_ext < 9'(NUM_SYMBOLS);
    assign in_sym     = in_sym_ext[SW-1:0];
    assign in_xfer    = i_in.valid && i_in.ready;
    assign store_we   = in_xfer && (i_in.command == CMD_STORE) && in_sym_ok;
    assign st_head    = r_head[in_sym];
    assign st_count   = r_count[in_sym];
    assign st_full    = (st_count == CW'(WINDOW_DEPTH));
    assign st_sum     = (CW+1)'(st_head) + (CW+1)'(st_count);
    assign st_slot    = st_full ? st_head
                      : (st_sum >= (CW+1)'(WINDOW_DEPTH))
                        ? HW'(st_sum - (CW+1)'(WINDOW_DEPTH)) : HW'(st_sum);
    assign wr_addr    = AW'(in_sym) * AW'(WINDOW_DEPTH) + AW'(st_slot);

    // current slot of the query
    logic [HW-1:0]   cur_head;
    logic [CW-1:0]   cur_count;
    logic [AW-1:0]   rd_addr;
    logic [TIME_W:0] age;
    logic            too_old;
    logic            last_item;
    logic [HW-1:0]   ptr_inc;
    logic [HW-1:0]   head_inc;
    logic [MID_W-1:0] mid_diff;

    assign cur_head  = r_head[r_sym];
    assign cur_count = r_count[r_sym];
    assign rd_addr   = AW'(r_sym) * AW'(WINDOW_DEPTH)
                     + AW'((r_state == GS_PR_RD) ? cur_head : r_ptr);
    // a sample newer than the query time gives a negative age and stays
    assign age       = {1'b0, r_now} - {1'b0, r_q_time};
    assign too_old   = $signed(age) > $signed({{(TIME_W + 1 - WIN_W){1'b0}}, r_window_ms});
    assign last_item = (r_i == r_n - CW'(1));
    assign ptr_inc   = (r_ptr == HW'(WINDOW_DEPTH - 1)) ? '0 : r_ptr + HW'(1);
    assign head_inc  = (cur_head == HW'(WINDOW_DEPTH - 1)) ? '0 : cur_head + HW'(1);
    assign mid_diff  = (r_q_mid > r_prev) ? r_q_mid - r_prev : r_prev - r_q_mid;

    // shared divider
    logic             div_start;
    logic [MID_W-1:0] div_a;
    logic [MID_W-1:0] div_b;
    logic             div_scale;
    logic             div_done;
    logic [OUT_W-1:0] div_q;
    logic [OUT_W:0]   act_sum;

    assign act_sum = {1'b0, r_act} + {1'b0, div_q};

    wsrag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_b     (div_b),
        .i_scale (div_scale),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    logic out_free;
    assign out_free = !r_ov || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            GS_IDLE: begin
                if (in_xfer && i_in.command == CMD_QUERY) begin
                    n_state = in_sym_ok ? GS_PR_RD : GS_DONE;
                end
            end
            GS_PR_RD:  n_state = (cur_count == '0) ? GS_DONE : GS_PR_CHK;
            GS_PR_CHK: n_state = too_old ? GS_PR_RD : GS_W_RD;
            GS_W_RD:   n_state = GS_W_ACC;
            GS_W_ACC: begin
                n_state = (r_i != '0 && r_prev != '0) ? GS_W_DIV : GS_W_NEXT;
            end
            GS_W_DIV:  if (div_done) n_state = GS_W_NEXT;
            GS_W_NEXT: n_state = last_item ? GS_AVG_GO : GS_W_RD;
            GS_AVG_GO: n_state = GS_AVG_W;
            GS_AVG_W:  if (div_done) n_state = GS_RNG_GO;
            GS_RNG_GO: n_state = (r_lo == '0) ? GS_DONE : GS_RNG_W;
            GS_RNG_W:  if (div_done) n_state = GS_DONE;
            GS_DONE:   if (out_free) n_state = GS_IDLE;
            default:   n_state = GS_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_in.ready  = (r_state == GS_IDLE);
        i_cfg.ready = 1'b1;
        div_start   = 1'b0;
        div_a       = mid_diff;
        div_b       = r_prev;
        div_scale   = 1'b1;
        unique case (r_state)
            GS_W_ACC: div_start = (r_i != '0) && (r_prev != '0);
            GS_AVG_GO: begin
                div_start = 1'b1;
                div_a     = MID_W'(r_sum);
                div_b     = MID_W'(r_n);
                div_scale = 1'b0;
            end
            GS_RNG_GO: begin
                div_start = (r_lo != '0);
                div_a     = r_hi - r_lo;
                div_b     = r_lo;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms      <= WINDOW_MS_RST;
            r_max_avg_spread <= MAX_AVG_SPREAD_RST;
            r_min_range      <= MIN_RANGE_RST;
            r_min_activity   <= MIN_ACTIVITY_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_WINDOW_MS:      r_window_ms      <= i_cfg.data;
                REG_MAX_AVG_SPREAD: r_max_avg_spread <= i_cfg.data[OUT_W-1:0];
                REG_MIN_RANGE:      r_min_range      <= i_cfg.data[OUT_W-1:0];
                REG_MIN_ACTIVITY:   r_min_activity   <= i_cfg.data[OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ring heads and counts: advanced by stores, trimmed by pruning
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else if (store_we) begin
            if (st_full) begin
                r_head[in_sym] <= (st_head == HW'(WINDOW_DEPTH - 1)) ? '0 : st_head + HW'(1);
            end else begin
                r_count[in_sym] <= st_count + CW'(1);
            end
        end else if (r_state == GS_PR_CHK && too_old) begin
            r_head[r_sym]  <= head_inc;
            r_count[r_sym] <= cur_count - CW'(1);
        end
    end

    // sample memories
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            mem_time[wr_addr]   <= i_in.time_ms;
            mem_mid[wr_addr]    <= i_in.mid_price;
            mem_spread[wr_addr] <= i_in.spread_bps;
        end
        r_q_time   <= mem_time[rd_addr];
        r_q_mid    <= mem_mid[rd_addr];
        r_q_spread <= mem_spread[rd_addr];
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            GS_IDLE: begin
                r_sym <= in_sym;
                r_now <= i_in.time_ms;
                r_has <= 1'b0;
                r_avg <= '0;
                r_rng <= '0;
                r_act <= '0;
            end
            GS_PR_CHK: begin
                // window start found: set up the walk over retained samples
                r_n   <= cur_count;
                r_i   <= '0;
                r_ptr <= cur_head;
                r_sum <= '0;
                r_has <= !too_old;
            end
            GS_W_ACC: begin
                r_sum  <= r_sum + SUM_W'(r_q_spread);
                r_prev <= r_q_mid;
                if (r_i == '0 || r_q_mid < r_lo) r_lo <= r_q_mid;
                if (r_i == '0 || r_q_mid > r_hi) r_hi <= r_q_mid;
            end
            GS_W_DIV: begin
                if (div_done) r_act <= act_sum[OUT_W] ? SAT_MAX : act_sum[OUT_W-1:0];
            end
            GS_W_NEXT: begin
                r_i   <= r_i + CW'(1);
                r_ptr <= ptr_inc;
            end
            GS_AVG_W: begin
                if (div_done) r_avg <= div_q;
            end
            GS_RNG_W: begin
                if (div_done) r_rng <= div_q;
            end
            default: begin
            end
        endcase
    end

    // result register, held until the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == GS_DONE && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == GS_DONE && out_free) begin
            r_o_has <= r_has;
            r_o_avg <= r_avg;
            r_o_rng <= r_rng;
            r_o_act <= r_act;
            r_o_trd <= r_has && (r_avg <= r_max_avg_spread) && (r_rng >= r_min_range)
                       && (r_act >= r_min_activity);
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.has_data    = r_o_has;
    assign o_out.avg_spread  = r_o_avg;
    assign o_out.short_range = r_o_rng;
    assign o_out.activity    = r_o_act;
    assign o_out.tradable    = r_o_trd;

    // ring fill never exceeds its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_count <= CW'(WINDOW_DEPTH))
        else $error("ring count beyond depth");

    // walk index stays inside the retained samples
    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == GS_W_ACC) |-> (r_i < r_n))
        else $error("walk index out of range");

    // a divider start is never answered in the very next cycle
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !div_done)
        else $error("divider finished too early");

    // no new item is taken while a query is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != GS_IDLE) |-> !i_in.ready)
        else $error("input ready during query");
endmodule
`default_nettype wire

// File: verif/wsrag_tb_if.sv
// testbench package: ring depth used by the checker
`default_nettype none
package wsrag_tb_pkg;
    import wsrag_pkg::*;
    localparam int TB_DEPTH = WINDOW_DEPTH_DEF;
endpackage
`default_nettype wire

// File: verif/wsrag_checker.sv
// checker: watches the channels, predicts the window statistics and compares
`default_nettype none
module wsrag_checker import wsrag_pkg::*, wsrag_tb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wsrag_in_if       i_in,
    wsrag_out_if      i_out,
    wsrag_cfg_if      i_cfg,
    output int        o_fail_count,
    output int        o_pending
);
    localparam int DEPTH = TB_DEPTH;
    localparam int NSYM  = NUM_SYMBOLS_DEF;
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic             has_data;
        logic [OUT_W-1:0] avg_spread;
        logic [OUT_W-1:0] short_range;
        logic [OUT_W-1:0] activity;
        logic             tradable;
    } t_stats;

    logic [TIME_W-1:0] ring_time   [NSYM][DEPTH];
    logic [MID_W-1:0]  ring_mid    [NSYM][DEPTH];
    logic [SPR_W-1:0]  ring_spread [NSYM][DEPTH];
    int                head  [NSYM];
    int                count [NSYM];
    logic [WIN_W-1:0]  win_ms;
    logic [OUT_W-1:0]  spread_cap, range_floor, activity_floor;
    t_stats            exp_fifo [EXP_DEPTH];
    int                exp_wr;
    int                exp_rd;

    function automatic logic [OUT_W-1:0] sat24(logic [63:0] v);
        return (v > 64'(SAT_MAX)) ? SAT_MAX : v[OUT_W-1:0];
    endfunction

    task automatic store_sample(int s, logic [TIME_W-1:0] t, logic [MID_W-1:0] m,
                                logic [SPR_W-1:0] sp);
        int slot;
        if (count[s] < DEPTH) begin
            slot = (head[s] + count[s]) % DEPTH;
            count[s]++;
        end else begin
            slot = head[s];
            head[s] = (head[s] + 1) % DEPTH;
        end
        ring_time[s][slot] = t;
        ring_mid[s][slot] = m;
        ring_spread[s][slot] = sp;
    endtask

    function automatic t_stats window_stats(int s, logic [TIME_W-1:0] now);
        t_stats r;
        logic signed [63:0] age;
        logic [63:0] spread_sum, act, lo, hi, prev, m, d, rng;
        int idx;
        r = '0;
        spread_sum = 0;
        act = 0;
        rng = 0;
        while (count[s] > 0) begin
            age = $signed({16'd0, now}) - $signed({16'd0, ring_time[s][head[s]]});
            if (age > $signed({32'd0, win_ms})) begin
                head[s] = (head[s] + 1) % DEPTH;
                count[s]--;
            end else break;
        end
        if (count[s] == 0) return r;
        lo = ring_mid[s][head[s]];
        hi = lo;
        prev = lo;
        for (int i = 0; i < count[s]; i++) begin
            idx = (head[s] + i) % DEPTH;
            m = ring_mid[s][idx];
            spread_sum += ring_spread[s][idx];
            if (m < lo) lo = m;
            if (m > hi) hi = m;
            // zero previous mid skips the term
            if (i > 0 && prev != 0) begin
                d = (m > prev) ? m - prev : prev - m;
                act = sat24(act + sat24(d * 64'(SCALE_BPS) / prev));
            end
            prev = m;
        end
        if (lo != 0) rng = sat24((hi - lo) * 64'(SCALE_BPS) / lo);
        r.has_data = 1'b1;
        r.avg_spread = sat24(spread_sum / count[s]);
        r.short_range = rng[OUT_W-1:0];
        r.activity = act[OUT_W-1:0];
        r.tradable = (r.avg_spread <= spread_cap) && (r.short_range >= range_floor)
                     && (r.activity >= activity_floor);
        return r;
    endfunction

    assign o_pending = exp_wr - exp_rd;

    always @(posedge i_clk) begin
        t_stats e;
        if (!i_rst_n) begin
            for (int s = 0; s < NSYM; s++) begin
                head[s] = 0;
                count[s] = 0;
            end
            win_ms = WINDOW_MS_RST;
            spread_cap = MAX_AVG_SPREAD_RST;
            range_floor = MIN_RANGE_RST;
            activity_floor = MIN_ACTIVITY_RST;
            exp_wr = 0;
            exp_rd = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_WINDOW_MS:      win_ms = i_cfg.data;
                    REG_MAX_AVG_SPREAD: spread_cap = i_cfg.data[OUT_W-1:0];
                    REG_MIN_RANGE:      range_floor = i_cfg.data[OUT_W-1:0];
                    REG_MIN_ACTIVITY:   activity_floor = i_cfg.data[OUT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.command == CMD_STORE) begin
                    store_sample(i_in.symbol_index, i_in.time_ms, i_in.mid_price,
                                 i_in.spread_bps);
                end else begin
                    exp_fifo[exp_wr % EXP_DEPTH] = window_stats(i_in.symbol_index,
                                                                i_in.time_ms);
                    exp_wr++;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (exp_wr == exp_rd) begin
                    $error("unexpected result transfer");
                    o_fail_count++;
                end else begin
                    e = exp_fifo[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (i_out.has_data !== e.has_data) begin
                        $error("has_data expected %0d actual %0d", e.has_data, i_out.has_data);
                        o_fail_count++;
                    end
                    if (i_out.avg_spread !== e.avg_spread) begin
                        $error("avg_spread expected %0d actual %0d", e.avg_spread,
                               i_out.avg_spread);
                        o_fail_count++;
                    end
                    if (i_out.short_range !== e.short_range) begin
                        $error("short_range expected %0d actual %0d", e.short_range,
                               i_out.short_range);
                        o_fail_count++;
                    end
                    if (i_out.activity !== e.activity) begin
                        $error("activity expected %0d actual %0d", e.activity, i_out.activity);
                        o_fail_count++;
                    end
                    if (i_out.tradable !== e.tradable) begin
                        $error("tradable expected %0d actual %0d", e.tradable, i_out.tradable);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_windowed_spread_range_activity_gate.sv
// testbench top: clock, reset, stimulus and verdict for the activity gate
`default_nettype none
module tb_windowed_spread_range_activity_gate;
    import wsrag_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   calm;   // stretch with no idling on either side

    wsrag_in_if  in_ch ();
    wsrag_out_if out_ch ();
    wsrag_cfg_if cfg_ch ();

    windowed_spread_range_activity_gate u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    wsrag_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // result side stalls at random, about 13 percent of the time, never while calm
    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 13);
    end

    // per-slot clock so store timestamps mostly rise
    logic [TIME_W-1:0] slot_now [NUM_SYMBOLS_DEF];

    // valid stays high after a transfer until the next item or a pause drops it
    task automatic send(logic cmd, logic [SYM_W-1:0] sym, logic [TIME_W-1:0] t,
                        logic [MID_W-1:0] m, logic [SPR_W-1:0] sp);
        while (!calm && $urandom_range(99) < 13) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.symbol_index <= sym;
        in_ch.time_ms <= t;
        in_ch.mid_price <= m;
        in_ch.spread_bps <= sp;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // register writes only with nothing in flight, after a pause for a trailing query
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        logic [SYM_W-1:0] sym;
        logic [MID_W-1:0] m;
        for (int k = 0; k < n; k++) begin
            sym = SYM_W'($urandom_range(3));
            if ($urandom_range(99) < 25) begin
                // query a little after the slot's latest sample
                send(CMD_QUERY, sym, TIME_W'(slot_now[sym] + $urandom_range(1500)), '0, '0);
            end else begin
                slot_now[sym] = slot_now[sym] + TIME_W'($urandom_range(400));
                case ($urandom_range(9))
                    0: m = $urandom();
                    1: m = 0;
                    default: m = 32'd100000 + $urandom_range(400);
                endcase
                send(CMD_STORE, sym, slot_now[sym], m,
                     ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(700)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        calm = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_STORE;
        in_ch.symbol_index = '0;
        in_ch.time_ms = '0;
        in_ch.mid_price = '0;
        in_ch.spread_bps = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        for (int s = 0; s < NUM_SYMBOLS_DEF; s++) slot_now[s] = 48'd5000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty ring, extremes, zero mids, future sample, wraparound
        send(CMD_QUERY, 3'd7, '1, '1, '1);
        send(CMD_STORE, 3'd7, 48'd0, '1, '1);
        send(CMD_STORE, 3'd7, 48'd10, 32'd1, 16'd0);
        send(CMD_STORE, 3'd7, 48'd20, 32'd0, '1);
        send(CMD_STORE, 3'd7, 48'd30, 32'd7, 16'd5);
        send(CMD_QUERY, 3'd7, 48'd500, '0, '0);
        send(CMD_STORE, 3'd6, '1, 32'd0, 16'd1);
        send(CMD_STORE, 3'd6, '1, 32'd100, 16'd1);
        send(CMD_QUERY, 3'd6, 48'd0, '0, '0);
        send(CMD_QUERY, 3'd6, '1, '0, '0);
        for (int k = 0; k < 70; k++)
            send(CMD_STORE, 3'd5, 48'(k), 32'(1000 + k * 3), 16'(k));
        send(CMD_QUERY, 3'd5, 48'd60, '0, '0);
        send(CMD_QUERY, 3'd5, 48'd1040, '0, '0);
        send(CMD_QUERY, 3'd5, 48'd5000, '0, '0);

        write_reg(REG_WINDOW_MS, '1);
        write_reg(REG_MAX_AVG_SPREAD, 32'hFF_FFFF);
        write_reg(REG_MIN_RANGE, 32'd0);
        write_reg(REG_MIN_ACTIVITY, 32'd0);
        write_reg(8'd200, 32'd5);
        send(CMD_QUERY, 3'd7, 48'h8000_0000_0000, '0, '0);
        random_phase(40);

        calm = 1'b1;
        write_reg(REG_WINDOW_MS, 32'd0);
        write_reg(REG_MIN_RANGE, 32'hFF_FFFF);
        random_phase(40);
        calm = 1'b0;

        write_reg(REG_WINDOW_MS, 32'd1000);
        write_reg(REG_MAX_AVG_SPREAD, 32'd384);
        write_reg(REG_MIN_RANGE, 32'd128);
        write_reg(REG_MIN_ACTIVITY, 32'd128);
        random_phase(105);

        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_windowed_spread_range_activity_gate passed");
        end else begin
            $display("tb_windowed_spread_range_activity_gate failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #120000000;
        $display("tb_windowed_spread_range_activity_gate failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
rtl/core/wsrag_pkg.sv
rtl/core/wsrag_if.sv
rtl/core/wsrag_div.sv
rtl/core/windowed_spread_range_activity_gate.sv
verif/wsrag_tb_if.sv
verif/wsrag_checker.sv
verif/tb_windowed_spread_range_activity_gate.sv
